/* hdl/dpc_pkg.sv */
package dpc_pkg;

	typedef enum logic [2:0] {
		REG_PRINCIPAL_X  = 3'd0,
		REG_PRINCIPAL_Y  = 3'd1,
		REG_INV_FOCAL_X  = 3'd2,
		REG_INV_FOCAL_Y  = 3'd3,
		REG_INV_DEPTH_SC = 3'd4
	} dpc_reg_t;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [31:0] POS_SAT = 32'h7FFF_FFFF;
	localparam logic [31:0] NEG_SAT = 32'h8000_0000;

	typedef struct packed {
		logic en_s2;
		logic en_s3;
		logic en_s4;
	} dpc_adv_t;

endpackage

/* hdl/dpc_front.sv */
module dpc_front #(
	parameter int MAX_COLUMNS = 4096,
	parameter int MAX_ROWS    = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en_s1,
	input  logic        in_valid,
	input  logic [15:0] depth_sample,
	input  logic [11:0] column,
	input  logic [11:0] row,
	input  logic [7:0]  blue,
	input  logic [7:0]  green,
	input  logic [7:0]  red,
	input  logic [15:0] principal_x_q4,
	input  logic [15:0] principal_y_q4,
	input  logic [31:0] inv_depth_scale,
	output logic        valid_s1,
	output logic [31:0] z_s1,
	output logic [15:0] mag_x_s1,
	output logic        neg_x_s1,
	output logic [15:0] mag_y_s1,
	output logic        neg_y_s1,
	output logic [7:0]  blue_s1,
	output logic [7:0]  green_s1,
	output logic [7:0]  red_s1
);
	import dpc_pkg::*;

	localparam logic [16:0] COL_LIMIT = 17'(MAX_COLUMNS);
	localparam logic [16:0] ROW_LIMIT = 17'(MAX_ROWS);

	logic [15:0] scaled_x;
	logic [15:0] scaled_y;
	logic        neg_x;
	logic        neg_y;
	logic [47:0] dprod;
	logic        keep;

	assign scaled_x = {column, 4'b0000};
	assign scaled_y = {row, 4'b0000};
	assign neg_x    = scaled_x < principal_x_q4;
	assign neg_y    = scaled_y < principal_y_q4;
	assign dprod    = {32'b0, depth_sample} * {16'b0, inv_depth_scale};
	assign keep     = in_valid && (depth_sample != 16'd0)
		&& ({5'b0, column} < COL_LIMIT) && ({5'b0, row} < ROW_LIMIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en_s1) begin
			valid_s1 <= keep;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			z_s1     <= dprod[47:16];
			neg_x_s1 <= neg_x;
			neg_y_s1 <= neg_y;
			mag_x_s1 <= neg_x ? (principal_x_q4 - scaled_x) : (scaled_x - principal_x_q4);
			mag_y_s1 <= neg_y ? (principal_y_q4 - scaled_y) : (scaled_y - principal_y_q4);
			blue_s1  <= blue;
			green_s1 <= green;
			red_s1   <= red;
		end
	end

endmodule

/* hdl/dpc_lateral.sv */
module dpc_lateral (
	input  logic                clk,
	input  dpc_pkg::dpc_adv_t   adv,
	input  logic [15:0]         mag_s1,
	input  logic                neg_s1,
	input  logic [31:0]         z_s1,
	input  logic [31:0]         inv_f,
	output logic signed [31:0]  coord_s4
);
	import dpc_pkg::*;

	logic [47:0] a_s2;
	logic        neg_s2;
	logic [63:0] lo_s3;
	logic [47:0] hi_s3;
	logic        neg_s3;

	logic [79:0] total;
	logic [43:0] q;
	logic        rem;
	logic [44:0] qn;
	logic [31:0] res;

	// full product = hi * 2^32 + lo, result is floor(product >> 36)
	assign total = {hi_s3, 32'b0} + {16'b0, lo_s3};
	assign q     = total[79:36];
	assign rem   = |total[35:0];
	assign qn    = {1'b0, q} + {44'b0, rem};

	always_comb begin
		if (!neg_s3) begin
			res = (q > {12'b0, POS_SAT}) ? POS_SAT : q[31:0];
		end else if (qn > {13'b0, NEG_SAT}) begin
			res = NEG_SAT;
		end else begin
			res = 32'd0 - qn[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv.en_s2) begin
			a_s2   <= {32'b0, mag_s1} * {16'b0, z_s1};
			neg_s2 <= neg_s1;
		end
		if (adv.en_s3) begin
			lo_s3  <= {32'b0, a_s2[31:0]} * {32'b0, inv_f};
			hi_s3  <= {32'b0, a_s2[47:32]} * {16'b0, inv_f};
			neg_s3 <= neg_s2;
		end
		if (adv.en_s4) begin
			coord_s4 <= res;
		end
	end

endmodule

/* hdl/depth_to_point_cloud_projection.sv */
// Pinhole back-projection of depth pixels into Q16.16 points with color passed
// through. One request is taken every clock while in_stall is low; a result
// appears on out_valid after its request has passed the four register stages of
// the multiply chain (depth scale, lateral offset times z, then the 48x32 product
// split in two halves and recombined with rounding and saturation). Requests with
// zero depth or with a column/row outside MAX_COLUMNS/MAX_ROWS are consumed and
// produce no result. Configuration registers must only be written while the
// pipeline is empty.
module depth_to_point_cloud_projection #(
	parameter int MAX_COLUMNS = 4096,
	parameter int MAX_ROWS    = 4096
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [dpc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [dpc_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [15:0]                     depth_sample,
	input  logic [11:0]                     column,
	input  logic [11:0]                     row,
	input  logic [7:0]                      blue,
	input  logic [7:0]                      green,
	input  logic [7:0]                      red,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic signed [31:0]              point_x,
	output logic signed [31:0]              point_y,
	output logic [31:0]                     point_z,
	output logic [7:0]                      out_blue,
	output logic [7:0]                      out_green,
	output logic [7:0]                      out_red
);
	import dpc_pkg::*;

	logic [15:0] principal_x_q;
	logic [15:0] principal_y_q;
	logic [31:0] inv_focal_x_q;
	logic [31:0] inv_focal_y_q;
	logic [31:0] inv_depth_scale_q;

	logic        en_s1;
	dpc_adv_t    adv;

	logic        valid_s1, valid_s2, valid_s3, valid_s4;
	logic [31:0] z_s1, z_s2, z_s3, z_s4;
	logic [15:0] mag_x_s1, mag_y_s1;
	logic        neg_x_s1, neg_y_s1;
	logic [7:0]  blue_s1, blue_s2, blue_s3, blue_s4;
	logic [7:0]  green_s1, green_s2, green_s3, green_s4;
	logic [7:0]  red_s1, red_s2, red_s3, red_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			principal_x_q     <= '0;
			principal_y_q     <= '0;
			inv_focal_x_q     <= '0;
			inv_focal_y_q     <= '0;
			inv_depth_scale_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PRINCIPAL_X:  principal_x_q     <= cfg_data[15:0];
				REG_PRINCIPAL_Y:  principal_y_q     <= cfg_data[15:0];
				REG_INV_FOCAL_X:  inv_focal_x_q     <= cfg_data;
				REG_INV_FOCAL_Y:  inv_focal_y_q     <= cfg_data;
				REG_INV_DEPTH_SC: inv_depth_scale_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// bubbles collapse: a stage moves when empty or when the next one moves
	assign adv.en_s4 = !valid_s4 || !out_stall;
	assign adv.en_s3 = !valid_s3 || adv.en_s4;
	assign adv.en_s2 = !valid_s2 || adv.en_s3;
	assign en_s1     = !valid_s1 || adv.en_s2;
	assign in_stall  = !en_s1;

	dpc_front #(
		.MAX_COLUMNS (MAX_COLUMNS),
		.MAX_ROWS    (MAX_ROWS)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.en_s1           (en_s1),
		.in_valid        (in_valid),
		.depth_sample    (depth_sample),
		.column          (column),
		.row             (row),
		.blue            (blue),
		.green           (green),
		.red             (red),
		.principal_x_q4  (principal_x_q),
		.principal_y_q4  (principal_y_q),
		.inv_depth_scale (inv_depth_scale_q),
		.valid_s1        (valid_s1),
		.z_s1            (z_s1),
		.mag_x_s1        (mag_x_s1),
		.neg_x_s1        (neg_x_s1),
		.mag_y_s1        (mag_y_s1),
		.neg_y_s1        (neg_y_s1),
		.blue_s1         (blue_s1),
		.green_s1        (green_s1),
		.red_s1          (red_s1)
	);

	dpc_lateral u_lat_x (
		.clk      (clk),
		.adv      (adv),
		.mag_s1   (mag_x_s1),
		.neg_s1   (neg_x_s1),
		.z_s1     (z_s1),
		.inv_f    (inv_focal_x_q),
		.coord_s4 (point_x)
	);

	dpc_lateral u_lat_y (
		.clk      (clk),
		.adv      (adv),
		.mag_s1   (mag_y_s1),
		.neg_s1   (neg_y_s1),
		.z_s1     (z_s1),
		.inv_f    (inv_focal_y_q),
		.coord_s4 (point_y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (adv.en_s2) begin
				valid_s2 <= valid_s1;
			end
			if (adv.en_s3) begin
				valid_s3 <= valid_s2;
			end
			if (adv.en_s4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv.en_s2) begin
			z_s2     <= z_s1;
			blue_s2  <= blue_s1;
			green_s2 <= green_s1;
			red_s2   <= red_s1;
		end
		if (adv.en_s3) begin
			z_s3     <= z_s2;
			blue_s3  <= blue_s2;
			green_s3 <= green_s2;
			red_s3   <= red_s2;
		end
		if (adv.en_s4) begin
			z_s4     <= z_s3;
			blue_s4  <= blue_s3;
			green_s4 <= green_s3;
			red_s4   <= red_s3;
		end
	end

	assign out_valid = valid_s4;
	assign point_z   = z_s4;
	assign out_blue  = blue_s4;
	assign out_green = green_s4;
	assign out_red   = red_s4;

	a_zero_depth_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && depth_sample == 16'd0) |=> !valid_s1)
		else $error("zero-depth request entered the pipeline");

	a_stage3_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && valid_s4 && out_stall) |=> valid_s3)
		else $error("stage 3 item lost under output stall");

	a_zero_z_point: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && point_z == 32'd0) |-> (point_x == 32'sd0 && point_y == 32'sd0))
		else $error("nonzero lateral coordinate with zero depth");

endmodule
